>>> rtl/core/mte_pkg.sv
// shared types, constants and the character code table for the morse text encoder
package mte_pkg;

    localparam int SYM_W        = 2;
    localparam int MAX_SYMS     = 6;
    localparam int RUN_W        = SYM_W * MAX_SYMS;
    localparam int COUNT_W      = 3;
    localparam int CODE_MAX     = 5;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [SYM_W-1:0] SYM_DOT   = 2'd0;
    localparam logic [SYM_W-1:0] SYM_DASH  = 2'd1;
    localparam logic [SYM_W-1:0] SYM_SPACE = 2'd2;
    localparam logic [SYM_W-1:0] SYM_UNK   = 2'd3;

    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    // one character's run of symbols, symbol k in bits [2k+1:2k]
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [RUN_W-1:0]   syms;
    } cmd_t;

    // pat holds the code left aligned, first symbol in the top bit, 1 for dash
    typedef struct packed {
        logic               known;
        logic [COUNT_W-1:0] len;
        logic [CODE_MAX-1:0] pat;
    } code_t;

    function automatic code_t morse_lookup(input logic [7:0] lc);
        code_t c;
        c.known = 1'b1;
        unique case (lc)
            8'h61: begin c.len = 3'd2; c.pat = 5'b01000; end // a
            8'h62: begin c.len = 3'd4; c.pat = 5'b10000; end // b
            8'h63: begin c.len = 3'd4; c.pat = 5'b10100; end // c
            8'h64: begin c.len = 3'd3; c.pat = 5'b10000; end // d
            8'h65: begin c.len = 3'd1; c.pat = 5'b00000; end // e
            8'h66: begin c.len = 3'd4; c.pat = 5'b00100; end // f
            8'h67: begin c.len = 3'd3; c.pat = 5'b11000; end // g
            8'h68: begin c.len = 3'd4; c.pat = 5'b00000; end // h
            8'h69: begin c.len = 3'd2; c.pat = 5'b00000; end // i
            8'h6a: begin c.len = 3'd4; c.pat = 5'b01110; end // j
            8'h6b: begin c.len = 3'd3; c.pat = 5'b10100; end // k
            8'h6c: begin c.len = 3'd4; c.pat = 5'b01000; end // l
            8'h6d: begin c.len = 3'd2; c.pat = 5'b11000; end // m
            8'h6e: begin c.len = 3'd2; c.pat = 5'b10000; end // n
            8'h6f: begin c.len = 3'd3; c.pat = 5'b11100; end // o
            8'h70: begin c.len = 3'd4; c.pat = 5'b01100; end // p
            8'h71: begin c.len = 3'd4; c.pat = 5'b11010; end // q
            8'h72: begin c.len = 3'd3; c.pat = 5'b01000; end // r
            8'h73: begin c.len = 3'd3; c.pat = 5'b00000; end // s
            8'h74: begin c.len = 3'd1; c.pat = 5'b10000; end // t
            8'h75: begin c.len = 3'd3; c.pat = 5'b00100; end // u
            8'h76: begin c.len = 3'd4; c.pat = 5'b00010; end // v
            8'h77: begin c.len = 3'd3; c.pat = 5'b01100; end // w
            8'h78: begin c.len = 3'd4; c.pat = 5'b10010; end // x
            8'h79: begin c.len = 3'd4; c.pat = 5'b10110; end // y
            8'h7a: begin c.len = 3'd4; c.pat = 5'b11000; end // z
            8'h30: begin c.len = 3'd5; c.pat = 5'b11111; end // 0
            8'h31: begin c.len = 3'd5; c.pat = 5'b01111; end // 1
            8'h32: begin c.len = 3'd5; c.pat = 5'b00111; end // 2
            8'h33: begin c.len = 3'd5; c.pat = 5'b00011; end // 3
            8'h34: begin c.len = 3'd5; c.pat = 5'b00001; end // 4
            8'h35: begin c.len = 3'd5; c.pat = 5'b00000; end // 5
            8'h36: begin c.len = 3'd5; c.pat = 5'b10000; end // 6
            8'h37: begin c.len = 3'd5; c.pat = 5'b11000; end // 7
            8'h38: begin c.len = 3'd5; c.pat = 5'b11100; end // 8
            8'h39: begin c.len = 3'd5; c.pat = 5'b11110; end // 9
            default: begin
                c.known = 1'b0;
                c.len   = 3'd1;
                c.pat   = 5'b00000;
            end
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/morse_text_encoder.sv
// top level of the morse text encoder: front end, command queue, back end
// the first symbol of a character passes the command queue, the back end's current-run register and its output register
// throughput: one symbol per cycle while m_tready is high; a character gives 1 to 6 symbols,
//   sent one at a time through the back end's single output register
// the front end takes a new character each cycle while the command queue has room
// reset: synchronous active-low aresetn clears word state, queue and output stage
module morse_text_encoder #(
    parameter int QUEUE_DEPTH = mte_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [1:0] symbol, [7:2] zero
    output logic       m_tlast
);
    import mte_pkg::*;

    logic q_push;
    logic q_ready;
    logic q_valid;
    logic q_pop;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    mte_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    mte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_push),
        .wr_data  (push_cmd),
        .wr_ready (q_ready),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (pop_cmd)
    );

    mte_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_run_len: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (push_cmd.count != 3'd0) && (push_cmd.count <= 3'd6))
        else $error("symbol run length out of range");

    a_space_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && s_tdata == CHAR_SPACE) |-> (push_cmd.count == 3'd3))
        else $error("word gap run is not three symbols");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

>>> rtl/core/mte_front.sv
// front end: accepts characters, tracks word state and builds the symbol run
module mte_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] char_code
    input  logic          q_ready,
    output logic          q_push,
    output mte_pkg::cmd_t q_cmd
);
    import mte_pkg::*;

    logic               letter_in_word_reg;
    logic               letter_in_word_next;
    logic [7:0]         lc;
    code_t              code;
    logic [RUN_W-1:0]   body;
    logic [COUNT_W-1:0] body_len;

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    always_comb begin
        if (s_tdata >= CHAR_UPPER_A && s_tdata <= CHAR_UPPER_Z) begin
            lc = s_tdata + CASE_OFFSET;
        end else begin
            lc = s_tdata;
        end
        code = morse_lookup(lc);

        body = '0;
        if (code.known) begin
            body[1:0] = code.pat[4] ? SYM_DASH : SYM_DOT;
            body[3:2] = code.pat[3] ? SYM_DASH : SYM_DOT;
            body[5:4] = code.pat[2] ? SYM_DASH : SYM_DOT;
            body[7:6] = code.pat[1] ? SYM_DASH : SYM_DOT;
            body[9:8] = code.pat[0] ? SYM_DASH : SYM_DOT;
        end else begin
            body[1:0] = SYM_UNK;
        end
        body_len = code.len;

        if (s_tdata == CHAR_SPACE) begin
            q_cmd.syms          = '0;
            q_cmd.syms[1:0]     = SYM_SPACE;
            q_cmd.syms[3:2]     = SYM_SPACE;
            q_cmd.syms[5:4]     = SYM_SPACE;
            q_cmd.count         = 3'd3;
            letter_in_word_next = 1'b0;
        end else if (letter_in_word_reg) begin
            q_cmd.syms          = {body[RUN_W-SYM_W-1:0], SYM_SPACE};
            q_cmd.count         = body_len + 3'd1;
            letter_in_word_next = 1'b1;
        end else begin
            q_cmd.syms          = body;
            q_cmd.count         = body_len;
            letter_in_word_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            letter_in_word_reg <= 1'b0;
        end else if (q_push) begin
            letter_in_word_reg <= letter_in_word_next;
        end
    end

endmodule

>>> rtl/core/mte_queue.sv
// short command queue between front and back end
module mte_queue #(
    parameter int DEPTH = mte_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  mte_pkg::cmd_t wr_data,
    output logic          wr_ready,
    input  logic          rd_en,
    output logic          rd_valid,
    output mte_pkg::cmd_t rd_data
);
    import mte_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_en && wr_ready;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/mte_back.sv
// back end: shifts out one symbol per cycle, unless the output stalls, through a registered output stage
module mte_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  mte_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,   // [1:0] symbol, [7:2] zero
    output logic          m_tlast
);
    import mte_pkg::*;

    logic               cur_valid_reg;
    logic [RUN_W-1:0]   cur_syms_reg;
    logic [COUNT_W-1:0] cur_rem_reg;
    logic               out_valid_reg;
    logic [SYM_W-1:0]   out_sym_reg;
    logic               out_last_reg;
    logic               out_free;
    logic               emit;
    logic               cur_done;
    logic               load;

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = cur_valid_reg && out_free;
    assign cur_done = emit && (cur_rem_reg == 3'd1);
    assign load     = !cur_valid_reg || cur_done;
    assign q_pop    = load && q_valid;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - SYM_W){1'b0}}, out_sym_reg};
    assign m_tlast  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                cur_valid_reg <= q_valid;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_free) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_syms_reg <= q_cmd.syms;
            cur_rem_reg  <= q_cmd.count;
        end else if (emit) begin
            cur_syms_reg <= {{SYM_W{1'b0}}, cur_syms_reg[RUN_W-1:SYM_W]};
            cur_rem_reg  <= cur_rem_reg - 3'd1;
        end
        if (emit) begin
            out_sym_reg  <= cur_syms_reg[SYM_W-1:0];
            out_last_reg <= (cur_rem_reg == 3'd1);
        end
    end

endmodule

>>> test/morse_text_encoder_test.sv
// self-checking testbench for the morse text encoder: directed table, random text, stalls
`timescale 1ns / 1ps

module morse_text_encoder_test;

    import mte_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_CHARS = 155;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 12;
    localparam int NUM_ROWS = 25;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } morse_sym_t;

    // n = 0 means the run is worked out by the encoder model
    typedef struct packed {
        logic [COUNT_W-1:0] n;
        logic [RUN_W-1:0]   syms;
    } typed_run_t;

    typedef struct packed {
        logic [7:0]   ch;
        typed_run_t   run;
    } row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;   // [7:0] char_code
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [1:0] symbol, [7:2] zero
    logic       m_tlast;

    morse_sym_t symbol_exp_q[$];
    morse_sym_t run_q[$];
    typed_run_t typed_q[$];
    row_t       plan[NUM_ROWS];
    logic       in_word = 1'b0;
    logic       steady = 1'b0;

    int fail_count = 0;
    int chars_sent = 0;
    int syms_checked = 0;
    int unk_count = 0;
    int word_gaps = 0;
    int idle_cycles = 0;

    morse_text_encoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // dot/dash pattern for a-z then 0-9
    function automatic string morse_pattern(input int idx);
        case (idx)
            0: return ".-";      1: return "-...";    2: return "-.-.";    3: return "-..";
            4: return ".";       5: return "..-.";    6: return "--.";     7: return "....";
            8: return "..";      9: return ".---";    10: return "-.-";    11: return ".-..";
            12: return "--";     13: return "-.";     14: return "---";    15: return ".--.";
            16: return "--.-";   17: return ".-.";    18: return "...";    19: return "-";
            20: return "..-";    21: return "...-";   22: return ".--";    23: return "-..-";
            24: return "-.--";   25: return "--..";
            26: return "-----";  27: return ".----";  28: return "..---";  29: return "...--";
            30: return "....-";  31: return ".....";  32: return "-....";  33: return "--...";
            34: return "---..";  default: return "----.";
        endcase
    endfunction

    // fills run_q with the symbols one character produces and updates the word state
    function automatic void encode_char(input logic [7:0] code);
        logic [7:0] lc;
        int         idx;
        int         k;
        string      pat;
        run_q.delete();
        if (code == CHAR_SPACE) begin
            repeat (3) run_q.push_back('{SYM_SPACE, 1'b0});
            in_word = 1'b0;
        end else begin
            lc = code;
            idx = -1;
            if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z)
                lc = code + CASE_OFFSET;
            if (lc >= "a" && lc <= "z")
                idx = int'(lc - "a");
            else if (lc >= "0" && lc <= "9")
                idx = 26 + int'(lc - "0");
            if (in_word)
                run_q.push_back('{SYM_SPACE, 1'b0});
            if (idx >= 0) begin
                pat = morse_pattern(idx);
                for (k = 0; k < pat.len(); k++)
                    run_q.push_back('{(pat[k] == "-") ? SYM_DASH : SYM_DOT, 1'b0});
            end else begin
                run_q.push_back('{SYM_UNK, 1'b0});
            end
            in_word = 1'b1;
        end
        run_q[run_q.size() - 1].last = 1'b1;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_char(input logic [7:0] ch, input typed_run_t run);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        typed_q.push_back(run);
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chars_sent++;
    endtask

    function automatic logic [7:0] random_text_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 8'("a") + 8'($urandom_range(0, 25));
        else if (r < 75)
            return CHAR_UPPER_A + 8'($urandom_range(0, 25));
        else if (r < 92)
            return 8'("0") + 8'($urandom_range(0, 9));
        return 8'($urandom_range(0, 255));
    endfunction

    // accepted transactions on both sides, prediction, checking and the stall watchdog
    always @(posedge aclk) begin
        morse_sym_t exp_sym;
        typed_run_t run;
        int k;
        if (aresetn) begin
            idle_cycles = idle_cycles + 1;
            if (s_tvalid && s_tready) begin
                idle_cycles = 0;
                run = typed_q.pop_front();
                encode_char(s_tdata);
                if (run.n != '0) begin
                    run_q.delete();
                    for (k = 0; k < int'(run.n); k++)
                        run_q.push_back('{run.syms[2*k +: 2], k == int'(run.n) - 1});
                end
                foreach (run_q[i]) begin
                    if (run_q[i].symbol == SYM_UNK)
                        unk_count++;
                    symbol_exp_q.push_back(run_q[i]);
                end
                if (s_tdata == CHAR_SPACE)
                    word_gaps++;
            end
            if (m_tvalid && m_tready) begin
                idle_cycles = 0;
                if (symbol_exp_q.size() == 0) begin
                    $display("%0t: unexpected symbol, expected none actual %0d last %0b",
                             $time, m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    exp_sym = symbol_exp_q.pop_front();
                    syms_checked++;
                    if (m_tdata != 8'(exp_sym.symbol)) begin
                        $display("%0t: symbol mismatch, expected %0d actual %0d",
                                 $time, exp_sym.symbol, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast != exp_sym.last) begin
                        $display("%0t: last mismatch, expected %0b actual %0b",
                                 $time, exp_sym.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d symbols outstanding",
                         $time, idle_cycles, symbol_exp_q.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial begin
        int n;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge aclk);
            end else begin
                n = idle_len();
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
        end
    end

    initial begin
        int i;
        int len;
        int sent;
        logic [7:0] ch;

        // after reset, extremes and the unknown mark are typed in; the rest is predicted
        plan[0]  = '{8'h45, '{3'd1, RUN_W'(SYM_DOT)}};
        plan[1]  = '{8'h00, '{3'd2, RUN_W'({SYM_UNK, SYM_SPACE})}};
        plan[2]  = '{8'hff, '{3'd2, RUN_W'({SYM_UNK, SYM_SPACE})}};
        plan[3]  = '{CHAR_SPACE, '{3'd3, RUN_W'({SYM_SPACE, SYM_SPACE, SYM_SPACE})}};
        plan[4]  = '{CHAR_SPACE, '{3'd3, RUN_W'({SYM_SPACE, SYM_SPACE, SYM_SPACE})}};
        plan[5]  = '{8'h30, '{3'd5, RUN_W'({SYM_DASH, SYM_DASH, SYM_DASH, SYM_DASH,
                                             SYM_DASH})}};
        plan[6]  = '{8'h68, '0};
        plan[7]  = '{8'h69, '0};
        plan[8]  = '{8'h61, '0};
        plan[9]  = '{8'h5a, '0};
        plan[10] = '{8'h7a, '0};
        plan[11] = '{8'h41, '0};
        plan[12] = '{8'h40, '0};
        plan[13] = '{8'h5b, '0};
        plan[14] = '{8'h60, '0};
        plan[15] = '{8'h7b, '0};
        plan[16] = '{8'h2f, '0};
        plan[17] = '{8'h3a, '0};
        plan[18] = '{8'h39, '0};
        plan[19] = '{8'h7f, '0};
        plan[20] = '{8'h80, '0};
        plan[21] = '{CHAR_SPACE, '0};
        plan[22] = '{8'h35, '0};
        plan[23] = '{8'h51, '0};
        plan[24] = '{8'h78, '0};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < NUM_ROWS; i++)
            send_char(plan[i].ch, plan[i].run);

        // random words with spaces between them, with some raw bytes mixed in
        sent = 0;
        while (sent < RANDOM_CHARS) begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 8) begin
                len = $urandom_range(1, 7);
                repeat (len) begin
                    send_char(random_text_char(), '0);
                    sent++;
                end
                send_char(CHAR_SPACE, '0);
                sent++;
                if ($urandom_range(0, 9) == 0) begin
                    send_char(CHAR_SPACE, '0);
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    ch = 8'($urandom_range(0, 255));
                    send_char(ch, '0);
                    sent++;
                end
            end
        end
        s_tvalid <= 1'b0;

        while (symbol_exp_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d characters sent (%0d word gaps), %0d symbols checked, %0d unknown marks",
                 chars_sent, word_gaps, syms_checked, unk_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
